// ----- hdl/bsm_pkg.sv -----
`default_nettype none
package bsm_pkg;

   localparam int NUM_BANK_REGS = 8;
   localparam int BANK_IDX_W = $clog2(NUM_BANK_REGS);

   localparam int PRG_COUNT_W = 7;
   localparam int CHR_COUNT_W = 9;
   localparam int CSR_DATA_W = CHR_COUNT_W;
   localparam int CSR_INDEX_W = 1;

   localparam int ADDR_W = 16;
   localparam int VALUE_W = 8;
   localparam int PRG_BANK_W = 6;
   localparam int CHR_BANK_W = 8;

   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 40;

   localparam logic [PRG_COUNT_W-1:0] PRG_COUNT_RESET = 7'd32;
   localparam logic [CHR_COUNT_W-1:0] CHR_COUNT_RESET = 9'd128;

   localparam logic [CSR_INDEX_W-1:0] CSR_PRG_COUNT = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHR_COUNT = 1'b1;

   localparam logic MODE_CPU = 1'b0;
   localparam logic MODE_PPU = 1'b1;

   // cpu write window selected by addr[14:13] when addr[15] is set
   localparam logic [1:0] REGION_BANK = 2'b00;
   localparam logic [1:0] REGION_MIRROR = 2'b01;
   localparam logic [1:0] REGION_IRQ_LATCH = 2'b10;
   localparam logic [1:0] REGION_IRQ_ENABLE = 2'b11;

   localparam logic [7:0] BANK_SECOND_LAST = 8'hFE;
   localparam logic [7:0] BANK_LAST = 8'hFF;

   localparam int PRG_SWAP_BIT = 6;
   localparam int CHR_SWAP_BIT = 7;
   localparam int A12_BIT = 12;

   typedef struct packed {
      logic irq_line;
      logic mirror;
      logic [7:0] bank_select;
      logic [NUM_BANK_REGS-1:0][7:0] bank_regs;
   } view_type;

endpackage
`default_nettype wire

// ----- hdl/bank_switch_mapper_with_scanline_irq.sv -----
`default_nettype none
// Bank-switching mapper with scanline interrupt counter.
// req channel: one beat per cpu register write (req_tuser 0) or ppu
// pattern fetch (req_tuser 1). req_tdata carries the address in [15:0]
// and the write byte in [23:16]; the byte is ignored on fetches.
// rsp channel: exactly one beat per req beat, in order, carrying the irq
// line, mirroring, the four 8 KB program banks and, for a fetch, the 1 KB
// pattern bank of the fetched slot (zero for a cpu write).
// csr port: csr_index 0 sets the program bank count, 1 the pattern bank
// count (0 selects pattern RAM); the user writes it only while the block
// is idle, the block does not enforce this. Throughput: one beat per
// cycle unless rsp stalls; the mapper state update and the bank resolve
// sit between the input register and the result register. When rsp is
// stalled, one further beat is held in the input register and req_tready
// drops after that. Synchronous reset clears all mapper state, empties
// both registers and restores bank counts 32 and 128.
module bank_switch_mapper_with_scanline_irq (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   output logic req_tready,
   // [15:0] addr, [23:16] value
   input wire logic [bsm_pkg::REQ_TDATA_W-1:0] req_tdata,
   // [0] mode
   input wire logic req_tuser,
   output logic rsp_tvalid,
   input wire logic rsp_tready,
   // [0] irq, [1] mirror_horizontal, [7:2] prg_bank_0, [13:8] prg_bank_1,
   // [19:14] prg_bank_2, [25:20] prg_bank_3, [33:26] chr_bank, [39:34] zero
   output logic [bsm_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic csr_we,
   input wire logic [bsm_pkg::CSR_INDEX_W-1:0] csr_index,
   input wire logic [bsm_pkg::CSR_DATA_W-1:0] csr_wdata
);

   logic in_valid_ff, in_valid_in;
   logic in_mode_ff;
   logic [bsm_pkg::ADDR_W-1:0] in_addr_ff;
   logic [bsm_pkg::VALUE_W-1:0] in_value_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic [bsm_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [bsm_pkg::PRG_COUNT_W-1:0] prg_count_ff;
   logic [bsm_pkg::CHR_COUNT_W-1:0] chr_count_ff;

   logic advance;
   logic req_take;
   bsm_pkg::view_type view;
   logic [bsm_pkg::PRG_BANK_W-1:0] prg_bank_0, prg_bank_1, prg_bank_2, prg_bank_3;
   logic [bsm_pkg::CHR_BANK_W-1:0] chr_bank;

   assign advance = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = req_take || (in_valid_ff && !advance);
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);
      rsp_data_in = {6'd0, chr_bank, prg_bank_3, prg_bank_2, prg_bank_1, prg_bank_0,
                     view.mirror, view.irq_line};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         prg_count_ff <= bsm_pkg::PRG_COUNT_RESET;
         chr_count_ff <= bsm_pkg::CHR_COUNT_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               bsm_pkg::CSR_PRG_COUNT: prg_count_ff <= csr_wdata[bsm_pkg::PRG_COUNT_W-1:0];
               bsm_pkg::CSR_CHR_COUNT: chr_count_ff <= csr_wdata;
               default: chr_count_ff <= chr_count_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_mode_ff <= req_tuser;
         in_addr_ff <= req_tdata[bsm_pkg::ADDR_W-1:0];
         in_value_ff <= req_tdata[bsm_pkg::ADDR_W +: bsm_pkg::VALUE_W];
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   bsm_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .mode  (in_mode_ff),
      .addr  (in_addr_ff),
      .value (in_value_ff),
      .view  (view)
   );

   bsm_resolve u_resolve (
      .view       (view),
      .prg_count  (prg_count_ff),
      .chr_count  (chr_count_ff),
      .mode       (in_mode_ff),
      .addr       (in_addr_ff),
      .prg_bank_0 (prg_bank_0),
      .prg_bank_1 (prg_bank_1),
      .prg_bank_2 (prg_bank_2),
      .prg_bank_3 (prg_bank_3),
      .chr_bank   (chr_bank)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

`ifndef SYNTHESIS
   a_held_beat_stays: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff)
      else $error("held input beat lost");

   a_advance_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced beat gave no response");

   a_full_blocks_req: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && rsp_valid_ff && !rsp_tready |-> !req_tready)
      else $error("request taken while both registers full");

   a_cpu_chr_zero: assert property (@(posedge clock) disable iff (reset)
      advance && in_mode_ff == bsm_pkg::MODE_CPU |=> rsp_data_ff[33:26] == '0)
      else $error("cpu write beat with nonzero pattern bank");
`endif

endmodule
`default_nettype wire

// ----- hdl/bsm_core.sv -----
`default_nettype none
module bsm_core (
   input wire logic clock,
   input wire logic reset,
   input wire logic step,
   input wire logic mode,
   input wire logic [bsm_pkg::ADDR_W-1:0] addr,
   input wire logic [bsm_pkg::VALUE_W-1:0] value,
   output bsm_pkg::view_type view
);

   logic [7:0] bank_select_ff, bank_select_in;
   logic [bsm_pkg::NUM_BANK_REGS-1:0][7:0] bank_regs_ff, bank_regs_in;
   logic [7:0] reload_ff, reload_in;
   logic [7:0] count_ff, count_in;
   logic enable_ff, enable_in;
   logic line_ff, line_in;
   logic prev_a12_ff, prev_a12_in;
   logic mirror_ff, mirror_in;

   logic odd;
   logic a12;

   always_comb begin
      bank_select_in = bank_select_ff;
      bank_regs_in = bank_regs_ff;
      reload_in = reload_ff;
      count_in = count_ff;
      enable_in = enable_ff;
      line_in = line_ff;
      prev_a12_in = prev_a12_ff;
      mirror_in = mirror_ff;
      odd = addr[0];
      a12 = addr[bsm_pkg::A12_BIT];
      if (mode == bsm_pkg::MODE_CPU) begin
         if (addr[bsm_pkg::ADDR_W-1]) begin
            case (addr[14:13])
               bsm_pkg::REGION_BANK: begin
                  if (!odd) begin
                     bank_select_in = value;
                  end else begin
                     bank_regs_in[bank_select_ff[bsm_pkg::BANK_IDX_W-1:0]] = value;
                  end
               end
               bsm_pkg::REGION_MIRROR: begin
                  if (!odd) begin
                     mirror_in = value[0];
                  end
               end
               bsm_pkg::REGION_IRQ_LATCH: begin
                  if (!odd) begin
                     reload_in = value;
                  end else begin
                     count_in = 8'd0;
                  end
               end
               bsm_pkg::REGION_IRQ_ENABLE: begin
                  if (!odd) begin
                     enable_in = 1'b0;
                     line_in = 1'b0;
                  end else begin
                     enable_in = 1'b1;
                  end
               end
               default: begin
                  bank_select_in = bank_select_ff;
               end
            endcase
         end
      end else begin
         if (!prev_a12_ff && a12) begin
            if (count_ff == 8'd0) begin
               count_in = reload_ff;
            end else begin
               count_in = count_ff - 8'd1;
            end
            if (count_in == 8'd0 && enable_ff) begin
               line_in = 1'b1;
            end
         end
         prev_a12_in = a12;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_select_ff <= '0;
         bank_regs_ff <= '0;
         reload_ff <= '0;
         count_ff <= '0;
         enable_ff <= 1'b0;
         line_ff <= 1'b0;
         prev_a12_ff <= 1'b0;
         mirror_ff <= 1'b0;
      end else if (step) begin
         bank_select_ff <= bank_select_in;
         bank_regs_ff <= bank_regs_in;
         reload_ff <= reload_in;
         count_ff <= count_in;
         enable_ff <= enable_in;
         line_ff <= line_in;
         prev_a12_ff <= prev_a12_in;
         mirror_ff <= mirror_in;
      end
   end

   // post-update view of the item now at the input register
   assign view.irq_line = line_in;
   assign view.mirror = mirror_in;
   assign view.bank_select = bank_select_in;
   assign view.bank_regs = bank_regs_in;

endmodule
`default_nettype wire

// ----- hdl/bsm_resolve.sv -----
`default_nettype none
module bsm_resolve (
   input wire bsm_pkg::view_type view,
   input wire logic [bsm_pkg::PRG_COUNT_W-1:0] prg_count,
   input wire logic [bsm_pkg::CHR_COUNT_W-1:0] chr_count,
   input wire logic mode,
   input wire logic [bsm_pkg::ADDR_W-1:0] addr,
   output logic [bsm_pkg::PRG_BANK_W-1:0] prg_bank_0,
   output logic [bsm_pkg::PRG_BANK_W-1:0] prg_bank_1,
   output logic [bsm_pkg::PRG_BANK_W-1:0] prg_bank_2,
   output logic [bsm_pkg::PRG_BANK_W-1:0] prg_bank_3,
   output logic [bsm_pkg::CHR_BANK_W-1:0] chr_bank
);

   logic [bsm_pkg::PRG_COUNT_W-1:0] prg_mask;
   logic [bsm_pkg::CHR_COUNT_W-1:0] chr_mask;
   logic swap_prg;
   logic [7:0] raw_0;
   logic [7:0] raw_2;
   logic [2:0] slot;
   logic [bsm_pkg::BANK_IDX_W-1:0] chr_idx;
   logic [7:0] chr_reg;
   logic [7:0] chr_raw;

   always_comb begin
      prg_mask = prg_count - 7'd1;
      chr_mask = chr_count - 9'd1;
      swap_prg = view.bank_select[bsm_pkg::PRG_SWAP_BIT];
      raw_0 = swap_prg ? bsm_pkg::BANK_SECOND_LAST : view.bank_regs[6];
      raw_2 = swap_prg ? view.bank_regs[6] : bsm_pkg::BANK_SECOND_LAST;
      prg_bank_0 = raw_0[5:0] & prg_mask[5:0];
      prg_bank_1 = view.bank_regs[7][5:0] & prg_mask[5:0];
      prg_bank_2 = raw_2[5:0] & prg_mask[5:0];
      prg_bank_3 = bsm_pkg::BANK_LAST[5:0] & prg_mask[5:0];

      // 2 KB slots pair one register, the 1 KB slots use R2..R5
      slot = addr[12:10] ^ {view.bank_select[bsm_pkg::CHR_SWAP_BIT], 2'b00};
      if (slot[2]) begin
         chr_idx = slot - 3'd2;
      end else begin
         chr_idx = {2'b00, slot[1]};
      end
      chr_reg = view.bank_regs[chr_idx];
      if (slot[2]) begin
         chr_raw = chr_reg;
      end else if (slot[0]) begin
         chr_raw = chr_reg | 8'h01;
      end else begin
         chr_raw = chr_reg & 8'hFE;
      end

      if (mode == bsm_pkg::MODE_CPU) begin
         chr_bank = '0;
      end else if (chr_count == '0) begin
         chr_bank = {5'd0, chr_raw[2:0]};
      end else begin
         chr_bank = chr_raw & chr_mask[7:0];
      end
   end

endmodule
`default_nettype wire
